// ----- rtl/core/s2ale_pkg.sv -----
// ----------------------------------------------------------------------------
// s2ale_pkg
// Shared types, constants and the scan-code key table of the line editor.
// ----------------------------------------------------------------------------
package s2ale_pkg;

    // line store geometry
    localparam int LINE_DEPTH = 256;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    // command queue geometry
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // scan codes and characters
    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] ARROW_LEFT  = 8'h4B;
    localparam logic [7:0] ARROW_RIGHT = 8'h4D;
    localparam logic [7:0] SHIFT_LEFT  = 8'h2A;
    localparam logic [7:0] SHIFT_RIGHT = 8'h36;
    localparam logic [7:0] CAPS_LOCK   = 8'h3A;
    localparam logic [7:0] RELEASE_BIT = 8'h80;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CASE_GAP    = 8'd32;

    // work for the back end
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_HOME,
        OP_LEFT,
        OP_RIGHT,
        OP_BKSP,
        OP_TYPE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       upper;
    } cmd_t;

    // one result word
    typedef struct packed {
        logic             stored;
        logic [CNT_W-1:0] cursor;
        logic [CNT_W-1:0] length;
        logic             upper;
        logic [7:0]       last_key;
        logic [7:0]       last_move;
        logic             overflow;
    } res_t;

    // back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } bk_state_t;

    // set 1 make code to ascii, zero for keys without a character
    function automatic logic [7:0] key_lookup(input logic [6:0] idx);
        logic [7:0] ch;
        begin
            unique case (idx)
                7'h01: ch = 8'h1B;
                7'h02: ch = 8'h31;
                7'h03: ch = 8'h32;
                7'h04: ch = 8'h33;
                7'h05: ch = 8'h34;
                7'h06: ch = 8'h35;
                7'h07: ch = 8'h36;
                7'h08: ch = 8'h37;
                7'h09: ch = 8'h38;
                7'h0A: ch = 8'h39;
                7'h0B: ch = 8'h30;
                7'h0C: ch = 8'h2D;
                7'h0D: ch = 8'h3D;
                7'h0E: ch = 8'h08;
                7'h0F: ch = 8'h09;
                7'h10: ch = 8'h71;
                7'h11: ch = 8'h77;
                7'h12: ch = 8'h65;
                7'h13: ch = 8'h72;
                7'h14: ch = 8'h74;
                7'h15: ch = 8'h79;
                7'h16: ch = 8'h75;
                7'h17: ch = 8'h69;
                7'h18: ch = 8'h6F;
                7'h19: ch = 8'h70;
                7'h1A: ch = 8'h5B;
                7'h1B: ch = 8'h5D;
                7'h1C: ch = 8'h0A;
                7'h1E: ch = 8'h61;
                7'h1F: ch = 8'h73;
                7'h20: ch = 8'h64;
                7'h21: ch = 8'h66;
                7'h22: ch = 8'h67;
                7'h23: ch = 8'h68;
                7'h24: ch = 8'h6A;
                7'h25: ch = 8'h6B;
                7'h26: ch = 8'h6C;
                7'h27: ch = 8'h3B;
                7'h28: ch = 8'h27;
                7'h29: ch = 8'h60;
                7'h2B: ch = 8'h5C;
                7'h2C: ch = 8'h7A;
                7'h2D: ch = 8'h78;
                7'h2E: ch = 8'h63;
                7'h2F: ch = 8'h76;
                7'h30: ch = 8'h62;
                7'h31: ch = 8'h6E;
                7'h32: ch = 8'h6D;
                7'h33: ch = 8'h2C;
                7'h34: ch = 8'h2E;
                7'h35: ch = 8'h2F;
                7'h37: ch = 8'h2A;
                7'h39: ch = 8'h20;
                7'h4A: ch = 8'h2D;
                7'h4E: ch = 8'h2B;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// ----- rtl/core/s2ale_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// s2ale_cmd_fifo
// Short command queue between the decode front end and the line back end.
// ----------------------------------------------------------------------------
module s2ale_cmd_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  s2ale_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output s2ale_pkg::cmd_t  head_cmd,
    output logic             not_empty
);

    s2ale_pkg::cmd_t                        slot_reg [s2ale_pkg::CMDQ_DEPTH];
    logic [s2ale_pkg::CMDQ_PTR_W-1:0]       wr_ptr_reg;
    logic [s2ale_pkg::CMDQ_PTR_W-1:0]       wr_ptr_next;
    logic [s2ale_pkg::CMDQ_PTR_W-1:0]       rd_ptr_reg;
    logic [s2ale_pkg::CMDQ_PTR_W-1:0]       rd_ptr_next;
    logic [s2ale_pkg::CMDQ_CNT_W-1:0]       count_reg;
    logic [s2ale_pkg::CMDQ_CNT_W-1:0]       count_next;

    // status
    assign full      = (count_reg == s2ale_pkg::CMDQ_CNT_W'(s2ale_pkg::CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == s2ale_pkg::CMDQ_PTR_W'(s2ale_pkg::CMDQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + s2ale_pkg::CMDQ_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == s2ale_pkg::CMDQ_PTR_W'(s2ale_pkg::CMDQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + s2ale_pkg::CMDQ_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + s2ale_pkg::CMDQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - s2ale_pkg::CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/s2ale_front.sv -----
// ----------------------------------------------------------------------------
// s2ale_front
// Takes scan-code words, tracks the prefix and case flags and turns each
// word into one command for the line back end.
// ----------------------------------------------------------------------------
module s2ale_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       scan_byte,
    input  logic             clear,
    output logic             push,
    output s2ale_pkg::cmd_t  push_cmd,
    input  logic             q_full
);

    logic       enabled_reg;
    logic       ext_reg;
    logic       ext_next;
    logic       case_reg;
    logic       case_next;
    logic [7:0] key_ch;
    logic [7:0] typed_ch;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // table lookup and case swap
    always_comb
    begin
        key_ch   = s2ale_pkg::key_lookup(scan_byte[6:0]);
        typed_ch = key_ch;
        if (case_reg && key_ch != s2ale_pkg::CHAR_LF)
        begin
            if (key_ch >= 8'h61 && key_ch <= 8'h7A)
            begin
                typed_ch = key_ch - s2ale_pkg::CASE_GAP;
            end
            else if (key_ch >= 8'h41 && key_ch <= 8'h5A)
            begin
                typed_ch = key_ch + s2ale_pkg::CASE_GAP;
            end
        end
    end

    // classify the word
    always_comb
    begin
        ext_next       = ext_reg;
        case_next      = case_reg;
        push_cmd.op    = s2ale_pkg::OP_NONE;
        push_cmd.ch    = typed_ch;
        priority if (clear)
        begin
            push_cmd.op = s2ale_pkg::OP_CLEAR;
        end
        else if (!enabled_reg)
        begin
            push_cmd.op = s2ale_pkg::OP_HOME;
        end
        else if (scan_byte == s2ale_pkg::PREFIX_BYTE)
        begin
            ext_next = 1'b1;
        end
        else if (ext_reg)
        begin
            ext_next = 1'b0;
            if (scan_byte == s2ale_pkg::ARROW_LEFT)
            begin
                push_cmd.op = s2ale_pkg::OP_LEFT;
            end
            else if (scan_byte == s2ale_pkg::ARROW_RIGHT)
            begin
                push_cmd.op = s2ale_pkg::OP_RIGHT;
            end
        end
        else if ((scan_byte & s2ale_pkg::RELEASE_BIT) != 8'h00)
        begin
            if (scan_byte == (s2ale_pkg::SHIFT_LEFT | s2ale_pkg::RELEASE_BIT) ||
                scan_byte == (s2ale_pkg::SHIFT_RIGHT | s2ale_pkg::RELEASE_BIT))
            begin
                case_next = !case_reg;
            end
        end
        else if (scan_byte == s2ale_pkg::SHIFT_LEFT || scan_byte == s2ale_pkg::SHIFT_RIGHT ||
                 scan_byte == s2ale_pkg::CAPS_LOCK)
        begin
            case_next = !case_reg;
        end
        else if (key_ch == s2ale_pkg::CHAR_BS)
        begin
            push_cmd.op = s2ale_pkg::OP_BKSP;
        end
        else if (key_ch != 8'h00)
        begin
            push_cmd.op = s2ale_pkg::OP_TYPE;
        end
        else
        begin
            // key without a character
            push_cmd.op = s2ale_pkg::OP_NONE;
        end
        push_cmd.upper = case_next;
    end

    // flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            ext_reg     <= 1'b0;
            case_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enabled_reg <= cfg_wr_data;
            end
            if (push)
            begin
                ext_reg  <= ext_next;
                case_reg <= case_next;
            end
        end
    end

endmodule

// ----- rtl/core/s2ale_back.sv -----
// ----------------------------------------------------------------------------
// s2ale_back
// Carries out line commands on the line store, cursor and length, scans
// the store for the right arrow and holds the result word for the output.
// ----------------------------------------------------------------------------
module s2ale_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  s2ale_pkg::cmd_t  cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output s2ale_pkg::res_t  res
);

    localparam int AW = s2ale_pkg::ADDR_W;
    localparam int CW = s2ale_pkg::CNT_W;

    s2ale_pkg::bk_state_t            state_reg;
    s2ale_pkg::bk_state_t            state_next;

    logic [CW-1:0]                   cursor_reg;
    logic [CW-1:0]                   cursor_next;
    logic [CW-1:0]                   len_reg;
    logic [CW-1:0]                   len_next;
    logic [7:0]                      last_typed_reg;
    logic [7:0]                      last_typed_next;
    logic [7:0]                      last_arrow_reg;
    logic [7:0]                      last_arrow_next;

    // line store and per-entry valid bits
    logic [7:0]                      line_mem [s2ale_pkg::LINE_DEPTH];
    logic [s2ale_pkg::LINE_DEPTH-1:0] vld_reg;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic                            vld_clr_one;
    logic                            vld_clr_all;
    logic [AW-1:0]                   vld_clr_idx;
    logic [7:0]                      rd_data_reg;
    logic                            rd_vld_reg;

    // right arrow scan
    logic [AW-1:0]                   scan_idx_reg;
    logic [AW-1:0]                   scan_idx_next;
    logic                            chk_reg;
    logic                            chk_next;
    logic                            chk_last_reg;
    logic                            chk_last_next;
    logic                            move_ok_reg;
    logic                            move_ok_next;
    logic                            upper_reg;
    logic                            upper_next;
    logic                            zero_hit;
    logic                            start_scan;

    // output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    s2ale_pkg::res_t                 res_reg;
    s2ale_pkg::res_t                 res_next;
    logic                            out_free;
    logic                            load_out;
    logic                            stored;
    logic                            ovf;
    logic                            res_upper;

    assign out_free   = !out_valid_reg || out_ready;
    assign zero_hit   = !rd_vld_reg || (rd_data_reg == 8'h00);
    assign start_scan = cmd_valid && (cmd.op == s2ale_pkg::OP_RIGHT) &&
                        (cursor_reg != CW'(s2ale_pkg::LINE_DEPTH));
    assign out_valid  = out_valid_reg;
    assign res        = res_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            s2ale_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = s2ale_pkg::ST_SCAN;
                end
            end
            s2ale_pkg::ST_SCAN:
            begin
                if (chk_reg && (zero_hit || chk_last_reg))
                begin
                    state_next = s2ale_pkg::ST_FINISH;
                end
            end
            s2ale_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = s2ale_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = s2ale_pkg::ST_IDLE;
            end
        endcase
    end

    // command execution and result assembly
    always_comb
    begin
        cursor_next     = cursor_reg;
        len_next        = len_reg;
        last_typed_next = last_typed_reg;
        last_arrow_next = last_arrow_reg;
        scan_idx_next   = scan_idx_reg;
        chk_next        = chk_reg;
        chk_last_next   = chk_last_reg;
        move_ok_next    = move_ok_reg;
        upper_next      = upper_reg;
        cmd_pop         = 1'b0;
        load_out        = 1'b0;
        stored          = 1'b0;
        ovf             = 1'b0;
        res_upper       = upper_reg;
        mem_we          = 1'b0;
        mem_waddr       = cursor_reg[AW-1:0];
        vld_clr_one     = 1'b0;
        vld_clr_all     = 1'b0;
        vld_clr_idx     = AW'(cursor_reg - CW'(1));
        unique case (state_reg)
            s2ale_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    cmd_pop       = 1'b1;
                    upper_next    = cmd.upper;
                    scan_idx_next = '0;
                    chk_next      = 1'b0;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop   = 1'b1;
                    load_out  = 1'b1;
                    res_upper = cmd.upper;
                    unique case (cmd.op)
                        s2ale_pkg::OP_CLEAR:
                        begin
                            cursor_next     = '0;
                            len_next        = '0;
                            last_typed_next = 8'h00;
                            last_arrow_next = 8'h00;
                            vld_clr_all     = 1'b1;
                        end
                        s2ale_pkg::OP_HOME:
                        begin
                            cursor_next = '0;
                        end
                        s2ale_pkg::OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next     = cursor_reg - CW'(1);
                                last_arrow_next = s2ale_pkg::ARROW_LEFT;
                            end
                        end
                        s2ale_pkg::OP_BKSP:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next     = cursor_reg - CW'(1);
                                vld_clr_one     = 1'b1;
                                last_typed_next = s2ale_pkg::CHAR_BS;
                                if (len_reg != '0)
                                begin
                                    len_next = len_reg - CW'(1);
                                end
                            end
                        end
                        s2ale_pkg::OP_TYPE:
                        begin
                            if (cursor_reg == CW'(s2ale_pkg::LINE_DEPTH))
                            begin
                                ovf = 1'b1;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                cursor_next     = cursor_reg + CW'(1);
                                last_typed_next = cmd.ch;
                                stored          = 1'b1;
                                if (len_reg != CW'(s2ale_pkg::LINE_DEPTH))
                                begin
                                    len_next = len_reg + CW'(1);
                                end
                            end
                        end
                        // right arrow at the end of the store, or nothing to do
                        default:
                        begin
                            cursor_next = cursor_reg;
                        end
                    endcase
                end
            end
            s2ale_pkg::ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + AW'(1);
                chk_next      = 1'b1;
                chk_last_next = (scan_idx_reg == cursor_reg[AW-1:0]);
                if (chk_reg)
                begin
                    if (zero_hit)
                    begin
                        move_ok_next = 1'b0;
                        chk_next     = 1'b0;
                    end
                    else if (chk_last_reg)
                    begin
                        move_ok_next = 1'b1;
                        chk_next     = 1'b0;
                    end
                end
            end
            s2ale_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (move_ok_reg)
                    begin
                        cursor_next     = cursor_reg + CW'(1);
                        last_arrow_next = s2ale_pkg::ARROW_RIGHT;
                    end
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        res_next.stored    = stored;
        res_next.cursor    = cursor_next;
        res_next.length    = len_next;
        res_next.upper     = res_upper;
        res_next.last_key  = last_typed_next;
        res_next.last_move = last_arrow_next;
        res_next.overflow  = ovf;

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= s2ale_pkg::ST_IDLE;
            cursor_reg     <= '0;
            len_reg        <= '0;
            last_typed_reg <= 8'h00;
            last_arrow_reg <= 8'h00;
            chk_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            vld_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            len_reg        <= len_next;
            last_typed_reg <= last_typed_next;
            last_arrow_reg <= last_arrow_next;
            chk_reg        <= chk_next;
            out_valid_reg  <= out_valid_next;
            if (vld_clr_all)
            begin
                vld_reg <= '0;
            end
            else if (vld_clr_one)
            begin
                vld_reg[vld_clr_idx] <= 1'b0;
            end
            else if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        chk_last_reg <= chk_last_next;
        move_ok_reg  <= move_ok_next;
        upper_reg    <= upper_next;
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    // line store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= cmd.ch;
        end
        rd_data_reg <= line_mem[scan_idx_reg];
        rd_vld_reg  <= vld_reg[scan_idx_reg];
    end

endmodule

// ----- rtl/core/scancode_to_ascii_line_editor.sv -----
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor
// Set 1 scan-code line editor: decode, command queue and line back end.
// ----------------------------------------------------------------------------
// Each input word (a scan byte plus a clear flag) gives exactly one result
// word. The front end decodes and takes a word in the cycle it is offered
// while the two-entry command queue has room. The back end handles one
// command at a time, and each result passes through a queue slot and the
// result register before it is offered on the output. A right arrow with
// the cursor short of the end of the store walks the line store from entry
// 0 up to the cursor through its single read port, one entry per cycle.
// Clear empties the line through per-entry valid bits, with no clearing
// pass after reset. The user writes input_enabled through cfg_wr_en /
// cfg_wr_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module scancode_to_ascii_line_editor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // input_enabled
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] scan_byte
    input  logic        s_tuser,       // [0] clear
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // [0] stored, [9:1] cursor_pos,
                                       // [18:10] line_length, [19] upper_mode,
                                       // [27:20] last_key, [35:28] last_move_code,
                                       // [36] overflow, [39:37] zero
);

    logic             push;
    s2ale_pkg::cmd_t  push_cmd;
    logic             q_full;
    logic             pop;
    s2ale_pkg::cmd_t  head_cmd;
    logic             q_not_empty;
    s2ale_pkg::res_t  res;

    s2ale_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .scan_byte   (s_tdata),
        .clear       (s_tuser),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    s2ale_cmd_fifo u_cmdq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty)
    );

    s2ale_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    // result word packing, first field in the low bits
    assign m_tdata = {3'b000, res.overflow, res.last_move, res.last_key, res.upper,
                      res.length, res.cursor, res.stored};

endmodule

// ----- rtl/core/s2ale_checker.sv -----
// ----------------------------------------------------------------------------
// s2ale_checker
// Port-level checks of the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module s2ale_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

    // a stalled result word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

    // no result word right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
    else $error("result word offered right after reset");

    // a character is either stored or dropped, not both
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[36]))
    else $error("stored and overflow in the same word");

    // a stored character is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[27:20] != 8'h00)
    else $error("stored word with a zero last character");

endmodule

bind scancode_to_ascii_line_editor s2ale_checker u_s2ale_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
